FILE: rtl/pkmm_pkg.sv
package pkmm_pkg;

  localparam int KEY_W   = 12;
  localparam int DIST_W  = 24;
  localparam int TOTAL_W = 40;
  localparam int COUNT_W = 16;

  typedef struct packed {
    logic [KEY_W-1:0]  route_key;
    logic [DIST_W-1:0] distance;
  } in_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key_out;
    logic [DIST_W-1:0]  min_dist;
    logic [DIST_W-1:0]  max_dist;
    logic [TOTAL_W-1:0] total_dist;
    logic [DIST_W-1:0]  range_dist;
    logic [COUNT_W-1:0] step_count;
  } out_t;

  typedef struct packed {
    logic [DIST_W-1:0]  min_val;
    logic [DIST_W-1:0]  max_val;
    logic [TOTAL_W-1:0] total_val;
    logic [COUNT_W-1:0] count_val;
  } entry_t;

endpackage

FILE: rtl/pkmm_update.sv
module pkmm_update (
  input  logic [pkmm_pkg::DIST_W-1:0] dist_i,
  input  pkmm_pkg::entry_t            old_i,
  output pkmm_pkg::entry_t            new_o,
  output logic [pkmm_pkg::DIST_W-1:0] range_o
);

  logic [pkmm_pkg::TOTAL_W:0] sum;

  always_comb begin
    sum = {1'b0, old_i.total_val} + (pkmm_pkg::TOTAL_W+1)'(dist_i);

    // zero minimum means unset
    if ((old_i.min_val == '0) || (dist_i < old_i.min_val)) begin
      new_o.min_val = dist_i;
    end else begin
      new_o.min_val = old_i.min_val;
    end

    if (dist_i > old_i.max_val) begin
      new_o.max_val = dist_i;
    end else begin
      new_o.max_val = old_i.max_val;
    end

    if (sum[pkmm_pkg::TOTAL_W]) begin
      new_o.total_val = '1;
    end else begin
      new_o.total_val = sum[pkmm_pkg::TOTAL_W-1:0];
    end

    if (old_i.count_val != '1) begin
      new_o.count_val = old_i.count_val + 1'b1;
    end else begin
      new_o.count_val = old_i.count_val;
    end

    if (new_o.max_val >= new_o.min_val) begin
      range_o = new_o.max_val - new_o.min_val;
    end else begin
      range_o = '0;
    end
  end

endmodule

FILE: rtl/per_key_min_max_sum_count_top.sv
// Per-key min/max/total/count table in one synchronous RAM.
// Each request passes the key map (ST_DIV, ST_MOD), RAM read (ST_READ) and update
// (ST_UPD), which waits while the output register holds an untaken result; no new
// request is taken until that update is written. The next request is taken while a
// finished result waits in the output register. Reset: synchronous, then a clearing
// pass zeroes every RAM entry; in_ready stays low during the pass.
module per_key_min_max_sum_count_top #(
  parameter int NUM_KEYS = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pkmm_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output pkmm_pkg::out_t  out_data
);

  localparam int AW      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int SH      = 24;
  localparam int NK_W    = 17;
  localparam int PROD_W  = pkmm_pkg::KEY_W + NK_W;
  localparam logic [SH-1:0]     RECIP = SH'((2**SH) / NUM_KEYS);
  localparam logic [NK_W-1:0]   NK    = NK_W'(NUM_KEYS);
  localparam logic [AW-1:0]     LAST  = AW'(NUM_KEYS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_MOD   = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [pkmm_pkg::KEY_W-1:0]  key_r;
  logic [pkmm_pkg::DIST_W-1:0] dist_r;
  logic [pkmm_pkg::KEY_W-1:0]  quo_r;
  logic [AW-1:0]               addr_r;

  pkmm_pkg::entry_t mem [NUM_KEYS];
  pkmm_pkg::entry_t rd_data_r;
  pkmm_pkg::entry_t upd_entry;
  logic [pkmm_pkg::DIST_W-1:0] upd_range;

  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  pkmm_pkg::entry_t mem_wd;

  logic           out_valid_r;
  pkmm_pkg::out_t out_data_r;

  logic [pkmm_pkg::KEY_W+SH-1:0] quo_prod;
  logic [PROD_W-1:0]             back_prod;
  logic [pkmm_pkg::KEY_W-1:0]    rem0;
  logic [NK_W-1:0]               rem1;
  logic                          upd_go;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign upd_go    = (state_r == ST_UPD) && (!out_valid_r || out_ready);

  pkmm_update u_update (
    .dist_i  (dist_r),
    .old_i   (rd_data_r),
    .new_o   (upd_entry),
    .range_o (upd_range)
  );

  // key modulo NUM_KEYS: reciprocal multiply, then one correction
  always_comb begin
    quo_prod  = (pkmm_pkg::KEY_W+SH)'(key_r) * (pkmm_pkg::KEY_W+SH)'(RECIP);
    back_prod = PROD_W'(quo_r) * PROD_W'(NK);
    rem0      = key_r - back_prod[pkmm_pkg::KEY_W-1:0];
    if (NK_W'(rem0) >= NK) begin
      rem1 = NK_W'(rem0) - NK;
    end else begin
      rem1 = NK_W'(rem0);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    mem_we      = 1'b0;
    mem_wa      = addr_r;
    mem_wd      = upd_entry;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_cnt_r;
        mem_wd      = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV:  state_nxt = ST_MOD;
      ST_MOD:  state_nxt = ST_READ;
      ST_READ: state_nxt = ST_UPD;
      ST_UPD: begin
        if (upd_go) begin
          mem_we    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (upd_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_r  <= in_data.route_key;
      dist_r <= in_data.distance;
    end
    if (state_r == ST_DIV) begin
      quo_r <= quo_prod[pkmm_pkg::KEY_W+SH-1:SH];
    end
    if (state_r == ST_MOD) begin
      addr_r <= AW'(rem1);
    end
    if (upd_go) begin
      out_data_r.key_out    <= key_r;
      out_data_r.min_dist   <= upd_entry.min_val;
      out_data_r.max_dist   <= upd_entry.max_val;
      out_data_r.total_dist <= upd_entry.total_val;
      out_data_r.range_dist <= upd_range;
      out_data_r.step_count <= upd_entry.count_val;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[addr_r];
  end

endmodule

FILE: rtl/pkmm_checker.sv
module pkmm_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input pkmm_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.min_dist <= out_data.max_dist)
    else $error("min above max");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.range_dist == (out_data.max_dist - out_data.min_dist))
    else $error("range mismatch");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.step_count != '0 && out_data.total_dist >= 40'(out_data.max_dist))
    else $error("count or total inconsistent");

  a_new_key: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken during update");

endmodule

bind per_key_min_max_sum_count_top pkmm_checker u_pkmm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/pkmm_stats_check.sv
`timescale 1ns / 100ps
module pkmm_stats_check #(
  parameter int NUM_KEYS = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  pkmm_pkg::in_t       in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  pkmm_pkg::out_t      out_data,
  output int unsigned         n_fail,
  output int unsigned         n_pending,
  output int unsigned         n_checked
);

  localparam int DW = pkmm_pkg::DIST_W;
  localparam int TW = pkmm_pkg::TOTAL_W;
  localparam int CW = pkmm_pkg::COUNT_W;
  localparam logic [TW-1:0] TOTAL_CEIL = '1;
  localparam logic [CW-1:0] COUNT_CEIL = '1;

  logic [DW-1:0] min_tab   [NUM_KEYS];
  logic [DW-1:0] max_tab   [NUM_KEYS];
  logic [TW-1:0] total_tab [NUM_KEYS];
  logic [CW-1:0] count_tab [NUM_KEYS];

  pkmm_pkg::out_t expected_stats [$];
  pkmm_pkg::out_t want;

  // zero minimum reads as unset and is replaced by the next sample
  function automatic pkmm_pkg::out_t update_route_stats(pkmm_pkg::in_t req);
    int unsigned    e;
    logic [DW-1:0]  mn;
    logic [DW-1:0]  mx;
    logic [TW:0]    sum;
    logic [TW-1:0]  tot;
    logic [CW-1:0]  cnt;
    pkmm_pkg::out_t res;
    e   = req.route_key % NUM_KEYS;
    mn  = min_tab[e];
    mx  = max_tab[e];
    tot = total_tab[e];
    cnt = count_tab[e];
    if (mn == '0 || req.distance < mn) mn = req.distance;
    if (req.distance > mx) mx = req.distance;
    sum = {1'b0, tot} + {{(TW + 1 - DW){1'b0}}, req.distance};
    tot = sum[TW] ? TOTAL_CEIL : sum[TW-1:0];
    if (cnt != COUNT_CEIL) cnt = cnt + 1'b1;
    min_tab[e]     = mn;
    max_tab[e]     = mx;
    total_tab[e]   = tot;
    count_tab[e]   = cnt;
    res.key_out    = req.route_key;
    res.min_dist   = mn;
    res.max_dist   = mx;
    res.total_dist = tot;
    res.range_dist = (mx >= mn) ? mx - mn : '0;
    res.step_count = cnt;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [TW-1:0] want_v,
                             input logic [TW-1:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        min_tab[i]   = '0;
        max_tab[i]   = '0;
        total_tab[i] = '0;
        count_tab[i] = '0;
      end
      expected_stats.delete();
      n_fail    = 0;
      n_pending = 0;
      n_checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_stats.size() == 0) begin
          $error("result for key %0d with no request outstanding", out_data.key_out);
          n_fail++;
        end else begin
          want = expected_stats.pop_front();
          check_field("key_out", TW'(want.key_out), TW'(out_data.key_out));
          check_field("min_dist", TW'(want.min_dist), TW'(out_data.min_dist));
          check_field("max_dist", TW'(want.max_dist), TW'(out_data.max_dist));
          check_field("total_dist", want.total_dist, out_data.total_dist);
          check_field("range_dist", TW'(want.range_dist), TW'(out_data.range_dist));
          check_field("step_count", TW'(want.step_count), TW'(out_data.step_count));
          n_checked++;
        end
      end
      if (in_valid && in_ready) expected_stats.push_back(update_route_stats(in_data));
      n_pending = expected_stats.size();
    end
  end

endmodule

FILE: tb/per_key_min_max_sum_count_top_tb.sv
`timescale 1ns / 100ps
module per_key_min_max_sum_count_top_tb;

  localparam int RAND_REQS = 750;
  localparam int SAT_REQS  = 16;
  localparam logic [pkmm_pkg::KEY_W-1:0] SAT_KEY = 12'h123;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  pkmm_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  pkmm_pkg::out_t out_data;
  int unsigned n_fail;
  int unsigned n_pending;
  int unsigned n_checked;
  int unsigned n_sent;
  bit          steady;
  logic [pkmm_pkg::KEY_W-1:0] hot_keys [8];

  per_key_min_max_sum_count_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  pkmm_stats_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .n_fail    (n_fail),
    .n_pending (n_pending),
    .n_checked (n_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input logic [pkmm_pkg::KEY_W-1:0] key,
                              input logic [pkmm_pkg::DIST_W-1:0] sample_dist);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data.route_key  <= key;
    in_data.distance   <= sample_dist;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  initial begin : sink
    int run;
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      run = steady ? 1 : pick_gap() + 1;
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [pkmm_pkg::KEY_W-1:0]  key;
    logic [pkmm_pkg::DIST_W-1:0] sample_dist;
    int                          r;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    steady   = 1'b0;
    n_sent   = 0;
    hot_keys = '{12'h000, 12'h001, 12'h002, 12'h7FF, 12'h800, 12'hFFE, 12'hFFF,
                 12'h3C5};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero sample, unset min replaced, new min, new max
    send_request(12'h000, 24'd0);
    send_request(12'h000, 24'd500);
    send_request(12'h000, 24'd300);
    send_request(12'h000, 24'd900);
    send_request(12'h000, 24'd600);
    send_request(12'hFFF, 24'hFFFFFF);
    send_request(12'hFFF, 24'd1);
    send_request(12'hFFF, 24'd0);
    send_request(12'hFFF, 24'd7);
    send_request(12'hAAA, 24'hAAAAAA);
    send_request(12'h555, 24'h555555);
    send_request(12'h001, 24'd1);
    send_request(12'h001, 24'd0);
    send_request(12'h001, 24'd0);
    send_request(12'h001, 24'hFFFFFF);
    send_request(12'h800, 24'h800000);
    send_request(12'h7FF, 24'h7FFFFF);
    steady = 1'b1;
    send_request(12'h005, 24'd10);
    send_request(12'h005, 24'd20);
    send_request(12'h005, 24'd5);
    send_request(12'h006, 24'd3);
    send_request(12'h005, 24'd40);
    steady = 1'b0;

    for (int i = 0; i < RAND_REQS; i++) begin
      steady = (i % 150) >= 120;
      r = $urandom_range(0, 99);
      if (r < 60) key = hot_keys[$urandom_range(0, 7)];
      else if (r < 70) key = pkmm_pkg::KEY_W'(12'hFFF - $urandom_range(0, 3));
      else key = pkmm_pkg::KEY_W'($urandom_range(0, 4095));
      r = $urandom_range(0, 99);
      if (r < 10) sample_dist = '0;
      else if (r < 20) sample_dist = '1;
      else if (r < 45) sample_dist = pkmm_pkg::DIST_W'($urandom_range(1, 1000));
      else if (r < 55) sample_dist = pkmm_pkg::DIST_W'(24'hFFFFFF - $urandom_range(0, 1000));
      else sample_dist = pkmm_pkg::DIST_W'($urandom());
      send_request(key, sample_dist);
    end

    // back-to-back full-scale samples on one key
    steady = 1'b1;
    for (int i = 0; i < SAT_REQS; i++) send_request(SAT_KEY, '1);
    in_valid <= 1'b0;
    steady = 1'b0;

    while (n_checked != n_sent || n_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("directed, random and full-scale requests: %0d sent, %0d results checked",
             n_sent, n_checked);
    $display("mismatches: %0d", n_fail);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: per_key_min_max_sum_count_top.f
rtl/pkmm_pkg.sv
rtl/pkmm_update.sv
rtl/per_key_min_max_sum_count_top.sv
rtl/pkmm_checker.sv
tb/pkmm_stats_check.sv
tb/per_key_min_max_sum_count_top_tb.sv
